/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");

// The condition must never be seen at a clock edge.
`define ASSERT_NEVER(label, clk, rstn, cond) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_IMPLIES(label, clk, rstn, ante, cons)
`define ASSERT_NEVER(label, clk, rstn, cond)

`endif

`endif

/* sv/eijm_pkg.sv */
// ----------------------------------------------------------------------------
// eijm_pkg
// Types, widths and constants shared by the interval jitter monitor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package eijm_pkg;

    localparam int TS_W   = 48;
    localparam int MS_W   = 24;
    localparam int CNT_W  = 32;
    localparam int SUM_W  = 48;
    localparam int PER_W  = 16;
    localparam int CFG_W  = 24;
    localparam int DIFF_W = 34;
    localparam int STEP_W = 6;

    localparam int US_PER_MS      = 1000;
    localparam int DEFAULT_PERIOD = 200;
    localparam int CMD_DEPTH      = 4;

    // Smallest interval in microseconds whose millisecond count saturates.
    localparam logic [TS_W-1:0] SAT_DIFF_US = 48'd16777216000;

    // Divide by 1000 as a shift by 3 and a multiply by the rounded-up
    // reciprocal of 125, taking the product bits from MS_SHIFT upwards.
    // Exact for every interval below the saturation point.
    localparam int                 PRE_SHIFT = 3;
    localparam int                 RECIP_W   = 32;
    localparam logic [RECIP_W-1:0] MS_RECIP  = 32'd2199023256;
    localparam int                 MS_SHIFT  = 38;
    localparam int                 PROD_W    = DIFF_W - PRE_SHIFT + RECIP_W;

    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_EVENT  = 2'd1;
    localparam logic [1:0] ACT_REPORT = 2'd2;
    localparam logic [1:0] ACT_RESET  = 2'd3;

    localparam logic CFG_CRITICAL = 1'b0;
    localparam logic CFG_PERIOD   = 1'b1;

    typedef struct packed {
        logic [1:0]      action;
        logic [TS_W-1:0] timestamp_us;
    } in_item_t;

    typedef struct packed {
        logic [MS_W-1:0]  delta_ms;
        logic             is_critical;
        logic             new_max;
        logic             period_mark;
        logic [MS_W-1:0]  mean_ms;
        logic [CNT_W-1:0] window_count_out;
        logic [MS_W-1:0]  window_max_out;
        logic [MS_W-1:0]  overall_max_out;
    } out_item_t;

    // Classified item passed from front to back.
    typedef struct packed {
        logic [1:0]        op;
        logic              zero;
        logic              sat;
        logic [DIFF_W-1:0] diff;
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [CNT_W-1:0]  rem_init;
        logic [SUM_W-1:0]  dividend;
        logic [CNT_W-1:0]  divisor;
        logic [STEP_W-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [SUM_W-1:0] quotient;
        logic [CNT_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

/* sv/eijm_front.sv */
// ----------------------------------------------------------------------------
// eijm_front
// Accepts items, tracks the reference time and classifies each interval.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eijm_front
    import eijm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire in_item_t in_item,
    input  wire logic     q_full,
    output logic          q_wr,
    output cmd_t          q_cmd
);

    logic [TS_W-1:0] reference_time_reg;
    logic [TS_W-1:0] reference_time_next;
    logic            has_reference_reg;
    logic            has_reference_next;
    logic [TS_W:0]   diff_ext;

    assign q_wr = push && !q_full;

    always_comb
    begin
        diff_ext = {1'b0, in_item.timestamp_us} - {1'b0, reference_time_reg};

        q_cmd.op   = in_item.action;
        q_cmd.diff = diff_ext[DIFF_W-1:0];
        // zero interval: no reference, time ran backwards, or under one ms
        q_cmd.zero = !has_reference_reg || diff_ext[TS_W]
                     || (diff_ext[TS_W-1:0] < TS_W'(US_PER_MS));
        q_cmd.sat  = diff_ext[TS_W-1:0] >= SAT_DIFF_US;

        reference_time_next = reference_time_reg;
        has_reference_next  = has_reference_reg;
        if (q_wr)
        begin
            unique case (in_item.action) inside
                ACT_START, ACT_EVENT:
                begin
                    reference_time_next = in_item.timestamp_us;
                    has_reference_next  = 1'b1;
                end
                ACT_RESET:
                begin
                    reference_time_next = '0;
                    has_reference_next  = 1'b0;
                end
                default:
                begin
                    reference_time_next = reference_time_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reference_time_reg <= '0;
            has_reference_reg  <= 1'b0;
        end
        else
        begin
            reference_time_reg <= reference_time_next;
            has_reference_reg  <= has_reference_next;
        end
    end

endmodule

`default_nettype wire

/* sv/eijm_fifo.sv */
// ----------------------------------------------------------------------------
// eijm_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eijm_fifo
    import eijm_pkg::*;
#(
    parameter int DEPTH = CMD_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr,
    input  wire cmd_t wr_data,
    output logic      full,
    input  wire logic rd,
    output cmd_t      rd_data,
    output logic      valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign valid   = (count_reg != '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr && !full;
    assign do_rd   = rd && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

/* sv/eijm_div.sv */
// ----------------------------------------------------------------------------
// eijm_div
// Restoring divider, one quotient bit per cycle, shared by the back part.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eijm_div
    import eijm_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [CNT_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  rem_next;
    logic [SUM_W-1:0]  dvd_reg;
    logic [SUM_W-1:0]  dvd_next;
    logic [SUM_W-1:0]  quo_reg;
    logic [SUM_W-1:0]  quo_next;
    logic [CNT_W-1:0]  dvs_reg;
    logic [CNT_W-1:0]  dvs_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W:0]    rem_sh;
    logic              ge;

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    always_comb
    begin
        rem_sh = {rem_reg, dvd_reg[SUM_W-1]};
        ge     = rem_sh >= {1'b0, dvs_reg};

        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (req.start)
        begin
            rem_next  = req.rem_init;
            dvd_next  = req.dividend;
            quo_next  = '0;
            dvs_next  = req.divisor;
            step_next = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? CNT_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[CNT_W-1:0];
            dvd_next  = {dvd_reg[SUM_W-2:0], 1'b0};
            quo_next  = {quo_reg[SUM_W-2:0], ge};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

`default_nettype wire

/* sv/eijm_back.sv */
// ----------------------------------------------------------------------------
// eijm_back
// Carries out classified items: window statistics, divisions, result slot.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module eijm_back
    import eijm_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    input  wire cmd_t             cmd,
    output logic                  cmd_pop,
    input  wire logic [MS_W-1:0]  critical_ms,
    input  wire logic [PER_W-1:0] report_period,
    output div_req_t              div_req,
    input  wire div_rsp_t         div_rsp,
    output logic                  out_valid,
    input  wire logic             pop,
    output out_item_t             out_item
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_DELTA  = 6'b000010,
        S_UPDATE = 6'b000100,
        S_MARK   = 6'b001000,
        S_MEAN   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [MS_W-1:0]   window_max_reg;
    logic [MS_W-1:0]   window_max_next;
    logic [MS_W-1:0]   overall_max_reg;
    logic [MS_W-1:0]   overall_max_next;
    logic [SUM_W-1:0]  window_sum_reg;
    logic [SUM_W-1:0]  window_sum_next;
    logic [CNT_W-1:0]  window_count_reg;
    logic [CNT_W-1:0]  window_count_next;
    logic [DIFF_W-1:0] diff_reg;
    logic [DIFF_W-1:0] diff_next;
    out_item_t         res_reg;
    out_item_t         res_next;
    out_item_t         out_item_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              out_load;
    logic [SUM_W:0]    sum_ext;
    logic [CNT_W-1:0]  count_inc;
    logic [MS_W-1:0]   d;
    logic [PROD_W-1:0] ms_prod;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || pop);

    always_comb
    begin
        d         = res_reg.delta_ms;
        sum_ext   = {1'b0, window_sum_reg} + (SUM_W + 1)'(d);
        count_inc = (window_count_reg == '1) ? window_count_reg : window_count_reg + 1'b1;
        // interval in ms: drop three bits, then multiply by the reciprocal of 125
        ms_prod   = PROD_W'(diff_reg[DIFF_W-1:PRE_SHIFT]) * PROD_W'(MS_RECIP);

        state_next        = state_reg;
        window_max_next   = window_max_reg;
        overall_max_next  = overall_max_reg;
        window_sum_next   = window_sum_reg;
        window_count_next = window_count_reg;
        diff_next         = diff_reg;
        res_next          = res_reg;
        div_req           = '0;
        cmd_pop           = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop                   = 1'b1;
                    res_next                  = '0;
                    res_next.window_count_out = window_count_reg;
                    res_next.window_max_out   = window_max_reg;
                    res_next.overall_max_out  = overall_max_reg;
                    state_next                = S_DONE;
                    unique case (cmd.op)
                        ACT_EVENT:
                        begin
                            if (cmd.zero)
                            begin
                                state_next = S_DONE;
                            end
                            else if (cmd.sat)
                            begin
                                res_next.delta_ms = '1;
                                state_next        = S_UPDATE;
                            end
                            else
                            begin
                                diff_next  = cmd.diff;
                                state_next = S_DELTA;
                            end
                        end
                        ACT_REPORT:
                        begin
                            window_sum_next   = '0;
                            window_count_next = '0;
                            if (window_count_reg != '0)
                            begin
                                div_req.start    = 1'b1;
                                div_req.rem_init = '0;
                                div_req.dividend = window_sum_reg;
                                div_req.divisor  = window_count_reg;
                                div_req.steps    = STEP_W'(SUM_W);
                                state_next       = S_MEAN;
                            end
                        end
                        ACT_RESET:
                        begin
                            window_max_next           = '0;
                            window_sum_next           = '0;
                            window_count_next         = '0;
                            res_next.window_count_out = '0;
                            res_next.window_max_out   = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DELTA:
            begin
                // at least one ms here, so the window is always updated
                res_next.delta_ms = ms_prod[MS_SHIFT +: MS_W];
                state_next        = S_UPDATE;
            end
            S_UPDATE:
            begin
                if (d > window_max_reg)
                begin
                    window_max_next  = d;
                    res_next.new_max = 1'b1;
                    if (d > overall_max_reg)
                    begin
                        overall_max_next = d;
                    end
                end
                window_sum_next   = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                window_count_next = count_inc;
                res_next.is_critical      = d > critical_ms;
                res_next.window_count_out = count_inc;
                res_next.window_max_out   = (d > window_max_reg) ? d : window_max_reg;
                res_next.overall_max_out  = ((d > window_max_reg) && (d > overall_max_reg))
                                            ? d : overall_max_reg;
                if (report_period != '0)
                begin
                    div_req.start    = 1'b1;
                    div_req.rem_init = '0;
                    div_req.dividend = {count_inc, {(SUM_W - CNT_W){1'b0}}};
                    div_req.divisor  = CNT_W'(report_period);
                    div_req.steps    = STEP_W'(CNT_W);
                    state_next       = S_MARK;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MARK:
            begin
                if (div_rsp.done)
                begin
                    res_next.period_mark = (div_rsp.remainder == '0);
                    state_next           = S_DONE;
                end
            end
            S_MEAN:
            begin
                if (div_rsp.done)
                begin
                    res_next.mean_ms = (div_rsp.quotient[SUM_W-1:MS_W] != '0)
                                       ? '1 : div_rsp.quotient[MS_W-1:0];
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg  <= res_next;
        diff_reg <= diff_next;
        if (out_load)
        begin
            out_item_reg <= res_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            window_max_reg   <= '0;
            overall_max_reg  <= '0;
            window_sum_reg   <= '0;
            window_count_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            window_max_reg   <= window_max_next;
            overall_max_reg  <= overall_max_next;
            window_sum_reg   <= window_sum_next;
            window_count_reg <= window_count_next;
            out_valid_reg    <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

/* sv/event_interval_jitter_monitor.sv */
// ----------------------------------------------------------------------------
// event_interval_jitter_monitor
// Start, reset, zero-interval events and empty-window reports go straight to
// the result slot; other events pass ms conversion (not if saturated), window
// update and mark division (if report_period != 0), other reports the mean
// division. Reset: statistics cleared, report_period 200, critical_ms 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

// The front part holds the reference time. It takes the interval of each
// event, flags it as zero or saturated, and pushes a command into a short
// queue. The back part drains that queue one command at a time: it turns the
// interval into milliseconds with a reciprocal multiply, runs the shared
// restoring divider for the periodic mark and the window mean, keeps the
// window statistics, and places the finished item in a one-deep result slot.
// The queue keeps the input side open while the back part is busy or while a
// result waits to be taken.

module event_interval_jitter_monitor
    import eijm_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_DEPTH
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    // input item channel
    input  wire logic             push,
    output logic                  full,
    input  wire in_item_t         in_item,
    // result item channel
    output logic                  empty,
    input  wire logic             pop,
    output out_item_t             out_item,
    // configuration writes
    input  wire logic             cfg_we,
    input  wire logic             cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    logic [MS_W-1:0]  critical_ms_reg;
    logic [PER_W-1:0] report_period_reg;

    logic     q_wr;
    cmd_t     q_wr_cmd;
    logic     q_rd;
    cmd_t     q_rd_cmd;
    logic     q_valid;
    div_req_t div_req;
    div_rsp_t div_rsp;
    logic     out_valid;

    assign empty = !out_valid;

    // Configuration: hold both registers until written. Users must write only
    // while the block is idle (unenforced), so no item sees a change halfway.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            critical_ms_reg   <= '0;
            report_period_reg <= PER_W'(DEFAULT_PERIOD);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CRITICAL: critical_ms_reg   <= cfg_data[MS_W-1:0];
                CFG_PERIOD:   report_period_reg <= cfg_data[PER_W-1:0];
                default:      critical_ms_reg   <= critical_ms_reg;
            endcase
        end
    end

    // Front: accept items, advance the reference, classify the interval.
    eijm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .in_item (in_item),
        .q_full  (full),
        .q_wr    (q_wr),
        .q_cmd   (q_wr_cmd)
    );

    // Queue: decouple the front from the back.
    eijm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_wr),
        .wr_data (q_wr_cmd),
        .full    (full),
        .rd      (q_rd),
        .rd_data (q_rd_cmd),
        .valid   (q_valid)
    );

    // Back: drop each command into the statistics and build the result item.
    eijm_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (q_valid),
        .cmd           (q_rd_cmd),
        .cmd_pop       (q_rd),
        .critical_ms   (critical_ms_reg),
        .report_period (report_period_reg),
        .div_req       (div_req),
        .div_rsp       (div_rsp),
        .out_valid     (out_valid),
        .pop           (pop),
        .out_item      (out_item)
    );

    // Shared divider: count modulo period, window mean.
    eijm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // A new window maximum is the interval itself.
    `ASSERT_IMPLIES(a_new_max_is_delta, clk, rst_n, !empty && out_item.new_max, out_item.delta_ms == out_item.window_max_out)
    // The window maximum never passes the all-time maximum.
    `ASSERT_IMPLIES(a_window_below_overall, clk, rst_n, !empty, out_item.window_max_out <= out_item.overall_max_out)
    // A mean comes only from a window holding at least one interval.
    `ASSERT_IMPLIES(a_mean_needs_count, clk, rst_n, !empty && out_item.mean_ms != '0, out_item.window_count_out != '0)
    // Flags are raised only by a positive interval.
    `ASSERT_NEVER(a_flags_need_delta, clk, rst_n, !empty && (out_item.is_critical || out_item.new_max || out_item.period_mark) && out_item.delta_ms == '0)

endmodule

`default_nettype wire
